[hdl/xsr_pkg.sv]
// ----------------------------------------------------------------------------
// xsr_pkg
// Types, constants and helper functions shared by the xoshiro256++ unit.
// ----------------------------------------------------------------------------
package xsr_pkg;

  // Request kinds
  localparam logic [1:0] OP_RAW    = 2'd0;
  localparam logic [1:0] OP_FLOAT  = 2'd1;
  localparam logic [1:0] OP_RANGE  = 2'd2;
  localparam logic [1:0] OP_RESEED = 2'd3;

  // SplitMix64 constants
  localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL2   = 64'h94d049bb133111eb;
  localparam int unsigned MIX_SH1    = 30;
  localparam int unsigned MIX_SH2    = 27;
  localparam int unsigned MIX_SH3    = 31;

  // xoshiro256++ constants
  localparam int unsigned ROT_OUT    = 23;
  localparam int unsigned SHL_T      = 17;
  localparam int unsigned ROT_W3     = 45;
  localparam int unsigned FLOAT_POS  = 41;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [63:0]        seed;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
  } req_t;

  typedef struct packed {
    logic [63:0]        raw_value;
    logic [29:0]        unit_float_bits;
    logic signed [31:0] ranged_value;
    logic               bad_range;
  } rsp_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned n);
    return (v << n) | (v >> (64 - n));
  endfunction

  // IEEE single bits of m * 2^-23, m being 23 bits
  function automatic logic [29:0] unit_float(input logic [22:0] m);
    logic [4:0]  p;
    logic [22:0] mant;
    logic [6:0]  expo;
    p = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) p = 5'(i);
    end
    mant = m << (5'd23 - p);
    expo = 7'd104 + {2'b00, p};
    if (m == '0) return '0;
    return {expo, mant};
  endfunction

  // Assemble a whole result beat
  function automatic rsp_t make_rsp(input logic [63:0] raw, input logic [29:0] fbits,
                                    input logic [31:0] rval, input logic bad);
    rsp_t r;
    r.raw_value       = raw;
    r.unit_float_bits = fbits;
    r.ranged_value    = rval;
    r.bad_range       = bad;
    return r;
  endfunction

endpackage

[hdl/xsr_if.sv]
// ----------------------------------------------------------------------------
// xsr_if
// Valid/ready channels for requests and results of the xoshiro256++ unit.
// ----------------------------------------------------------------------------
interface xsr_req_if
  import xsr_pkg::*;
  ;
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface xsr_rsp_if
  import xsr_pkg::*;
  ;
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hdl/xsr_mul64.sv]
// ----------------------------------------------------------------------------
// xsr_mul64
// Low 64 bits of a 64 x 64 product from one 32 x 32 multiplier used in phases.
// ----------------------------------------------------------------------------
module xsr_mul64 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] product
);

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [1:0]  phase;
  logic        busy;
  logic [63:0] mul_q;
  logic [63:0] acc;
  logic [31:0] op_x;
  logic [31:0] op_y;

  // phase 0: lo*lo, phase 1: lo*hi, phase 2: hi*lo
  assign op_x = (phase == 2'd2) ? a_r[63:32] : a_r[31:0];
  assign op_y = (phase == 2'd1) ? b_r[63:32] : b_r[31:0];
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 2'd0;
      end else if (busy) begin
        phase <= phase + 2'd1;
        if (phase == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (busy) begin
      mul_q <= {32'd0, op_x} * {32'd0, op_y};
      case (phase)
        2'd0:    ;
        2'd1:    acc <= mul_q;
        default: acc[63:32] <= acc[63:32] + mul_q[31:0];
      endcase
    end
  end

endmodule

[hdl/xsr_rem_unit.sv]
// ----------------------------------------------------------------------------
// xsr_rem_unit
// Bit-serial remainder of a 64-bit word by a divisor of up to 2^32.
// ----------------------------------------------------------------------------
module xsr_rem_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);

  logic [63:0] dvd;
  logic [32:0] dsr;
  logic [32:0] rem_r;
  logic [5:0]  count;
  logic        busy;
  logic [33:0] shifted;
  logic [33:0] diff;

  assign shifted   = {rem_r, dvd[63]};
  assign diff      = shifted - {1'b0, dsr};
  assign remainder = rem_r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 6'd1;
        if (count == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring step: shift in the next dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      dsr   <= divisor;
      rem_r <= '0;
    end else if (busy) begin
      dvd <= {dvd[62:0], 1'b0};
      if (!diff[33]) rem_r <= diff[32:0];
      else           rem_r <= shifted[32:0];
    end
  end

endmodule

[hdl/xoshiro256pp_random_generator_unit.sv]
// ----------------------------------------------------------------------------
// xoshiro256pp_random_generator_unit
// xoshiro256++ generator with raw, unit float, ranged and reseed requests.
// ----------------------------------------------------------------------------
// One request is worked on at a time; ready is high only when the sequencer
// is idle, and a finished result waits in the output register so the next
// request can be taken meanwhile. Raw and unit float requests run one
// generator step over a sum state and a step state, then result forming.
// Reseed runs four SplitMix64 rounds, each with two 64-bit multiplies that
// run over a single 32 x 32 multiplier. Ranged requests work out the
// rejection threshold and the final reduction each with a bit-serial
// remainder of a 64-bit word, and a draw below the threshold is drawn again.
// Inverted bounds return bad_range without touching the state. A result
// that finds the output register still full holds the unit until that beat
// is taken. After reset the unit seeds itself from zero and is not ready
// until that seeding is done.
// ----------------------------------------------------------------------------
module xoshiro256pp_random_generator_unit
  import xsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  xsr_req_if.sink   req,
  xsr_rsp_if.source rsp
);

  localparam logic [3:0] ST_IDLE         = 4'd0;
  localparam logic [3:0] ST_MIX_ADD      = 4'd1;
  localparam logic [3:0] ST_MIX_M1       = 4'd2;
  localparam logic [3:0] ST_MIX_M2       = 4'd3;
  localparam logic [3:0] ST_ADV_SUM      = 4'd4;
  localparam logic [3:0] ST_ADV_STEP     = 4'd5;
  localparam logic [3:0] ST_FORM         = 4'd6;
  localparam logic [3:0] ST_RNG_SETUP    = 4'd7;
  localparam logic [3:0] ST_RNG_THR      = 4'd8;
  localparam logic [3:0] ST_RNG_THR_WAIT = 4'd9;
  localparam logic [3:0] ST_RNG_CHK      = 4'd10;
  localparam logic [3:0] ST_RNG_REM_WAIT = 4'd11;
  localparam logic [3:0] ST_EMIT         = 4'd12;

  logic [3:0]         state;
  logic               boot;
  logic [1:0]         op_r;
  logic signed [31:0] lo_r;
  logic signed [31:0] hi_r;

  // generator state and working registers
  logic [63:0] gen_word [4];
  logic [63:0] mix_v;
  logic [1:0]  word_idx;
  logic [63:0] sum_r;
  logic [63:0] draw_r;
  logic [32:0] range_r;
  logic [31:0] thr_r;
  rsp_t        result;

  // output register
  rsp_t out_q;
  logic out_valid;
  logic emit_fire;

  // shared units
  logic        mul_start;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [63:0] mul_prod;
  logic        rem_start;
  logic [63:0] rem_dividend;
  logic        rem_done;
  logic [31:0] rem_value;

  logic [63:0] mix_pre;
  logic [63:0] mix_mid;
  logic [63:0] mix_out;
  logic [63:0] adv_res;
  logic [63:0] shl_t;
  logic [63:0] nw0, nw1, nw2, nw3;
  logic        draw_low;
  logic [32:0] range_diff;

  // SplitMix64 stages around the two multiplies
  assign mix_pre = mix_v + MIX_GOLDEN;
  assign mix_mid = mul_prod ^ (mul_prod >> MIX_SH2);
  assign mix_out = mul_prod ^ (mul_prod >> MIX_SH3);

  assign mul_start = (state == ST_MIX_ADD) || ((state == ST_MIX_M1) && mul_done);
  assign mul_a     = (state == ST_MIX_ADD) ? (mix_pre ^ (mix_pre >> MIX_SH1)) : mix_mid;
  assign mul_b     = (state == ST_MIX_ADD) ? MIX_MUL1 : MIX_MUL2;

  // xoshiro256++ step: output sum was taken the cycle before
  assign adv_res = rotl64(sum_r, ROT_OUT) + gen_word[0];
  assign shl_t   = gen_word[1] << SHL_T;
  assign nw2     = gen_word[2] ^ gen_word[0];
  assign nw3     = gen_word[3] ^ gen_word[1];
  assign nw1     = gen_word[1] ^ nw2;
  assign nw0     = gen_word[0] ^ nw3;

  // ranged request: threshold is 2^64 mod range, worked as (0 - range) mod range
  assign range_diff   = {hi_r[31], hi_r} - {lo_r[31], lo_r};
  assign draw_low     = draw_r < {32'd0, thr_r};
  assign rem_start    = (state == ST_RNG_THR) || ((state == ST_RNG_CHK) && !draw_low);
  assign rem_dividend = (state == ST_RNG_THR) ? (64'd0 - {31'd0, range_r}) : draw_r;

  assign req.ready   = (state == ST_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_q;
  assign emit_fire   = (state == ST_EMIT) && (!out_valid || rsp.ready);

  xsr_mul64 u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  xsr_rem_unit u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (rem_dividend),
    .divisor   (range_r),
    .done      (rem_done),
    .remainder (rem_value)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_MIX_ADD;
      boot     <= 1'b1;
      mix_v    <= '0;
      word_idx <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            op_r <= req.payload.opcode;
            lo_r <= req.payload.lower_bound;
            hi_r <= req.payload.upper_bound;
            unique case (req.payload.opcode)
              OP_RANGE:  state <= ST_RNG_SETUP;
              OP_RESEED: begin
                mix_v    <= req.payload.seed;
                word_idx <= '0;
                state    <= ST_MIX_ADD;
              end
              default:   state <= ST_ADV_SUM;
            endcase
          end
        end
        ST_MIX_ADD: state <= ST_MIX_M1;
        ST_MIX_M1: begin
          if (mul_done) state <= ST_MIX_M2;
        end
        ST_MIX_M2: begin
          if (mul_done) begin
            // chain: each word seeds the next round
            gen_word[word_idx] <= mix_out;
            mix_v              <= mix_out;
            word_idx           <= word_idx + 2'd1;
            if (word_idx == 2'd3) begin
              if (boot) begin
                boot  <= 1'b0;
                state <= ST_IDLE;
              end else begin
                result <= '0;
                state  <= ST_EMIT;
              end
            end else begin
              state <= ST_MIX_ADD;
            end
          end
        end
        ST_ADV_SUM: begin
          sum_r <= gen_word[0] + gen_word[3];
          state <= ST_ADV_STEP;
        end
        ST_ADV_STEP: begin
          draw_r      <= adv_res;
          gen_word[0] <= nw0;
          gen_word[1] <= nw1;
          gen_word[2] <= nw2 ^ shl_t;
          gen_word[3] <= rotl64(nw3, ROT_W3);
          state       <= (op_r == OP_RANGE) ? ST_RNG_CHK : ST_FORM;
        end
        ST_FORM: begin
          if (op_r == OP_FLOAT) begin
            result <= make_rsp(64'd0, unit_float(draw_r[63:FLOAT_POS]), 32'd0, 1'b0);
          end else begin
            result <= make_rsp(draw_r, 30'd0, 32'd0, 1'b0);
          end
          state <= ST_EMIT;
        end
        ST_RNG_SETUP: begin
          if (lo_r > hi_r) begin
            // inverted bounds: flag and leave the state alone
            result <= make_rsp(64'd0, 30'd0, 32'd0, 1'b1);
            state  <= ST_EMIT;
          end else begin
            range_r <= range_diff + 33'd1;
            state   <= ST_RNG_THR;
          end
        end
        ST_RNG_THR: state <= ST_RNG_THR_WAIT;
        ST_RNG_THR_WAIT: begin
          if (rem_done) begin
            thr_r <= rem_value;
            state <= ST_ADV_SUM;
          end
        end
        ST_RNG_CHK: begin
          // drop draws below the threshold and draw again
          state <= draw_low ? ST_ADV_SUM : ST_RNG_REM_WAIT;
        end
        ST_RNG_REM_WAIT: begin
          if (rem_done) begin
            result <= make_rsp(64'd0, 30'd0, rem_value + lo_r, 1'b0);
            state  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_fire) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: hold the beat until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) out_q <= result;
  end

endmodule
